// ===== rtl/nts_pkg.sv =====
package nts_pkg;

  localparam int unsigned SilWidth    = 17;
  localparam int unsigned TickWidth   = 17;
  localparam int unsigned PerWidth    = 10;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  localparam logic [SilWidth-1:0]  SilenceReset = 17'd100000;
  localparam logic [TickWidth-1:0] TickMax      = 17'h1FFFF;
  localparam logic [3:0]           FirstRest    = 4'd14;

  typedef enum logic [1:0] {
    STG_IDLE = 2'd0,
    STG_HIGH = 2'd1,
    STG_LOW  = 2'd2,
    STG_SIL  = 2'd3
  } stage_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_OFFER = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] note_byte;
  } in_t;

  typedef struct packed {
    logic tone_out;
    logic busy_res;
    logic byte_taken;
  } out_t;

  // Classified item as it travels through the queue.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] hi_code;
    logic [3:0] lo_code;
    logic       hi_tone;
  } cmd_t;

  typedef struct packed {
    stage_t                stage;
    logic [2:0]            note;
    logic                  rep;
    logic [PerWidth-1:0]   periods;
    logic                  pin;
    logic [TickWidth-1:0]  tick;
    logic                  pv;
    logic [3:0]            pn;
  } seq_t;

  // Periods per repetition for A, B, C, D, E, F, G.
  function automatic logic [PerWidth-1:0] note_periods(input logic [2:0] n);
    logic [PerWidth-1:0] v;
    case (n)
      3'd0:    v = 10'd880;
      3'd1:    v = 10'd987;
      3'd2:    v = 10'd523;
      3'd3:    v = 10'd587;
      3'd4:    v = 10'd659;
      3'd5:    v = 10'd698;
      default: v = 10'd783;
    endcase
    return v;
  endfunction

  function automatic logic [PerWidth-1:0] note_high(input logic [2:0] n);
    logic [PerWidth-1:0] v;
    case (n)
      3'd0:    v = 10'd284;
      3'd1:    v = 10'd278;
      3'd2:    v = 10'd477;
      3'd3:    v = 10'd425;
      3'd4:    v = 10'd379;
      3'd5:    v = 10'd357;
      default: v = 10'd318;
    endcase
    return v;
  endfunction

  function automatic logic [PerWidth-1:0] note_low(input logic [2:0] n);
    logic [PerWidth-1:0] v;
    case (n)
      3'd0:    v = 10'd275;
      3'd1:    v = 10'd269;
      3'd2:    v = 10'd468;
      3'd3:    v = 10'd416;
      3'd4:    v = 10'd370;
      3'd5:    v = 10'd348;
      default: v = 10'd309;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/nts_front.sv =====
module nts_front import nts_pkg::*; (
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic push,
  output cmd_t push_cmd,
  input  logic q_ready
);

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // Split the byte into its two codes and mark whether the first one plays a tone.
  always_comb begin
    push_cmd.kind    = in_data.mode ? CMD_OFFER : CMD_TICK;
    push_cmd.hi_code = in_data.note_byte[7:4];
    push_cmd.lo_code = in_data.note_byte[3:0];
    push_cmd.hi_tone = (in_data.note_byte[7:4] < FirstRest);
  end

endmodule

// ===== rtl/nts_queue.sv =====
module nts_queue import nts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic q_ready,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t                 entry_r [QueueDepth];
  logic [QueueCntW-1:0] count_r, count_nxt;
  logic [QueuePtrW-1:0] wr_ptr_r, rd_ptr_r;

  assign q_ready = (count_r != QueueCntW'(QueueDepth));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == QueueCntW'(QueueDepth)) |-> !push)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QueueCntW'(QueueDepth))
    else $error("queue count out of range");

endmodule

// ===== rtl/nts_back.sv =====
module nts_back import nts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmd_t                q_cmd,
  output logic                pop,
  input  logic [SilWidth-1:0] silence,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data
);

  seq_t seq_r, seq_nxt;
  out_t out_r, res;
  logic out_valid_r;

  function automatic logic occupies(input logic [3:0] code, input logic [SilWidth-1:0] sil);
    return (code < FirstRest) || (sil != '0);
  endfunction

  function automatic seq_t start_code(input seq_t s_in, input logic [3:0] code,
                                      input logic [SilWidth-1:0] sil);
    seq_t s;
    s      = s_in;
    s.tick = '0;
    if (code < FirstRest) begin
      s.note    = code[3:1];
      s.rep     = code[0];
      s.periods = note_periods(code[3:1]);
      s.stage   = STG_HIGH;
      s.pin     = 1'b1;
    end else begin
      s.pin = 1'b0;
      if (sil != '0) begin
        s.stage = STG_SIL;
      end
    end
    return s;
  endfunction

  // At most one code can be pending, so this never needs more than one try.
  function automatic seq_t next_nibble(input seq_t s_in, input logic [SilWidth-1:0] sil);
    seq_t       s;
    logic [3:0] code;
    s    = s_in;
    code = s.pn;
    if (s.pv) begin
      s.pv = 1'b0;
      s.pn = '0;
      s    = start_code(s, code, sil);
      if (!occupies(code, sil)) begin
        s.stage = STG_IDLE;
        s.pin   = 1'b0;
        s.tick  = '0;
      end
    end else begin
      s.stage = STG_IDLE;
      s.pin   = 1'b0;
      s.tick  = '0;
    end
    return s;
  endfunction

  function automatic seq_t advance(input seq_t s_in, input logic [SilWidth-1:0] sil);
    seq_t                 s;
    logic [TickWidth-1:0] t;
    logic [PerWidth-1:0]  p;
    s = s_in;
    t = s.tick + 1'b1;
    p = s.periods;
    case (s.stage)
      STG_HIGH: begin
        if (t >= TickWidth'(note_high(s.note))) begin
          s.stage = STG_LOW;
          s.pin   = 1'b0;
          s.tick  = '0;
        end else begin
          s.tick = t;
        end
      end
      STG_LOW: begin
        if (t >= TickWidth'(note_low(s.note))) begin
          s.tick = '0;
          if (p != '0) begin
            p = p - 1'b1;
          end
          s.periods = p;
          if (p == '0) begin
            if (s.rep) begin
              s.rep     = 1'b0;
              s.periods = note_periods(s.note);
              s.stage   = STG_HIGH;
              s.pin     = 1'b1;
            end else begin
              s.pin = 1'b0;
              if (sil != '0) begin
                s.stage = STG_SIL;
              end else begin
                s = next_nibble(s, sil);
              end
            end
          end else begin
            s.stage = STG_HIGH;
            s.pin   = 1'b1;
          end
        end else begin
          s.tick = t;
        end
      end
      STG_SIL: begin
        if (s.tick != TickMax) begin
          s.tick = t;
        end
        if (s.tick >= sil) begin
          s = next_nibble(s, sil);
        end
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    seq_nxt        = seq_r;
    res.tone_out   = seq_r.pin;
    res.busy_res   = (seq_r.stage != STG_IDLE);
    res.byte_taken = 1'b0;
    if (q_cmd.kind == CMD_TICK) begin
      seq_nxt = advance(seq_r, silence);
    end else begin
      if (seq_r.stage == STG_IDLE) begin
        res.byte_taken = 1'b1;
        seq_nxt.pn     = q_cmd.lo_code;
        seq_nxt.pv     = 1'b1;
        seq_nxt        = start_code(seq_nxt, q_cmd.hi_code, silence);
        if (!(q_cmd.hi_tone || (silence != '0))) begin
          seq_nxt = next_nibble(seq_nxt, silence);
        end
      end
      res.tone_out = seq_nxt.pin;
      res.busy_res = (seq_nxt.stage != STG_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.stage   <= STG_IDLE;
      seq_r.note    <= '0;
      seq_r.rep     <= 1'b0;
      seq_r.periods <= '0;
      seq_r.pin     <= 1'b0;
      seq_r.tick    <= '0;
      seq_r.pv      <= 1'b0;
      seq_r.pn      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        seq_r       <= seq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.stage == STG_IDLE) |-> (!seq_r.pin && !seq_r.pv))
    else $error("idle sequencer holds a level or a pending code");

  a_pin_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.pin == (seq_r.stage == STG_HIGH)))
    else $error("pin level disagrees with stage");

  a_idle_result_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.busy_res) |-> !out_r.tone_out)
    else $error("tone driven while not busy");

  a_taken_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && res.byte_taken) |=> ($past(seq_r.stage) == STG_IDLE))
    else $error("byte taken while busy");

endmodule

// ===== rtl/nibble_tone_sequencer.sv =====
// Nibble tone sequencer: plays a note byte as a square wave on a one-bit speaker level.
// Input channel (in_valid/in_ready/in_data): each item is either a one-microsecond tick
// (mode 0) or the offer of a note byte (mode 1). A byte offered while the block is idle
// is taken; its upper code plays first, then its lower code. Codes 0 to 13 play a note
// (bits 3..1 pick A to G, bit 0 picks one or two repetitions); every code ends with a
// low gap of silence_ticks ticks, and codes 14 and 15 give only that gap. A byte offered
// while busy is dropped and reported with byte_taken low.
// Output channel (out_valid/out_ready/out_data): exactly one result item per input item,
// in order. For a tick it carries the level and busy flag during that tick; for an offer
// it carries the state after the offer.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes silence_ticks; it is always
// ready and should be used while no items are in flight.
// Timing: an item is accepted into a two-entry queue, the sequencer takes it from the
// queue when the output register is free or being read, and its result is then held in
// the output register. The sequencer retires one item per cycle, so the block sustains
// one item per clock cycle when the receiver keeps out_ready high.
// Reset (synchronous, rst_n low) empties the queue, leaves the sequencer idle with the
// level low, and sets silence_ticks to 100000. When the receiver stalls, the result
// holds in the output register, the queue fills its two entries, and in_ready drops.
module nibble_tone_sequencer import nts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SilWidth-1:0] cfg_data
);

  logic                silence_r;
  logic [SilWidth-1:0] silence_ticks_r;
  logic                push, pop, q_ready, q_valid;
  cmd_t                push_cmd, q_cmd;

  // The register write never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_ticks_r <= SilenceReset;
      silence_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        silence_ticks_r <= cfg_data;
      end
      silence_r <= (silence_ticks_r == '0);
    end
  end

  // Front end: takes items and sorts ticks from byte offers.
  nts_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  // Short queue that lets the front keep accepting while the back end is stalled.
  nts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  // Back end: the tone sequencer and the result register.
  nts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .silence   (silence_ticks_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A zero gap makes rest codes take no time; the flag follows the register next cycle.
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $stable(silence_ticks_r) |-> (silence_r == (silence_ticks_r == '0)))
    else $error("zero-gap flag out of step with register");

endmodule

// ===== tb/sv/tb_nibble_tone_sequencer.sv =====
module tb_nibble_tone_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import nts_pkg::*;

  // Cycle budget for the whole run. A correct run of a few hundred items stays inside it
  // even with the receiver at its sparsest.
  localparam int CYCLE_LIMIT = 50_000;

  // Note selects used by the directed tests.
  localparam logic [2:0] NOTE_A = 3'd0;
  localparam logic [2:0] NOTE_B = 3'd1;
  localparam logic [2:0] NOTE_G = 3'd6;
  localparam logic [3:0] LAST_REST = 4'd15;

  // Note timing, indexed by note select: periods per repetition, high and low half lengths.
  localparam logic [6:0][PerWidth-1:0] PERIODS_PER_REP =
    {10'd783, 10'd698, 10'd659, 10'd587, 10'd523, 10'd987, 10'd880};
  localparam logic [6:0][PerWidth-1:0] HIGH_TICKS =
    {10'd318, 10'd357, 10'd379, 10'd425, 10'd477, 10'd278, 10'd284};
  localparam logic [6:0][PerWidth-1:0] LOW_TICKS =
    {10'd309, 10'd348, 10'd370, 10'd416, 10'd468, 10'd269, 10'd275};

  // Receiver stall styles. Each one holds for a random window of cycles.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_COMB
  } rx_style_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SilWidth-1:0] cfg_data = '0;

  nibble_tone_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The player state below mirrors the sequencer as seen from its ports. It is advanced
  // once for every item that the block accepts, in acceptance order, so at any moment it
  // describes the block as the next item will find it.
  stage_t               play_stage = STG_IDLE;
  logic [2:0]           play_note = '0;
  logic                 play_second = 1'b0;
  logic [PerWidth-1:0]  play_periods = '0;
  logic                 play_pin = 1'b0;
  logic [TickWidth-1:0] play_tick = '0;
  logic                 queued_valid = 1'b0;
  logic [3:0]           queued_code = '0;
  logic [SilWidth-1:0]  gap_ticks = SilenceReset;

  out_t due_results[$];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int bytes_taken = 0;
  int bytes_dropped = 0;
  int cycles = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  bit rx_force_open = 1'b0;
  rx_style_t rx_style = RX_OPEN;
  int rx_window = 0;
  int rx_count = 0;

  // Starts one nibble. The result tells whether the nibble occupies at least one tick;
  // a rest code with a zero gap takes no time at all.
  function automatic bit begin_code(input logic [3:0] code);
    play_tick = '0;
    if (code < FirstRest) begin
      play_note = code[3:1];
      play_second = code[0];
      play_periods = PERIODS_PER_REP[code[3:1]];
      play_stage = STG_HIGH;
      play_pin = 1'b1;
      return 1'b1;
    end
    play_pin = 1'b0;
    if (gap_ticks != 0) begin
      play_stage = STG_SIL;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Moves on to the lower nibble if one is waiting, otherwise back to idle.
  function automatic void load_pending();
    logic [3:0] code;
    bit started;
    started = 1'b0;
    while (queued_valid && !started) begin
      code = queued_code;
      queued_valid = 1'b0;
      queued_code = '0;
      started = begin_code(code);
    end
    if (!started) begin
      play_stage = STG_IDLE;
      play_pin = 1'b0;
      play_tick = '0;
    end
  endfunction

  // One microsecond of playing time.
  function automatic void step_tick();
    case (play_stage)
      STG_HIGH: begin
        play_tick = play_tick + 1'b1;
        if (play_tick >= HIGH_TICKS[play_note]) begin
          play_stage = STG_LOW;
          play_pin = 1'b0;
          play_tick = '0;
        end
      end
      STG_LOW: begin
        play_tick = play_tick + 1'b1;
        if (play_tick >= LOW_TICKS[play_note]) begin
          play_tick = '0;
          if (play_periods != 0) play_periods = play_periods - 1'b1;
          if (play_periods != 0) begin
            play_stage = STG_HIGH;
            play_pin = 1'b1;
          end else if (play_second) begin
            // The second repetition reloads the full period count.
            play_second = 1'b0;
            play_periods = PERIODS_PER_REP[play_note];
            play_stage = STG_HIGH;
            play_pin = 1'b1;
          end else begin
            play_pin = 1'b0;
            if (gap_ticks != 0) play_stage = STG_SIL;
            else load_pending();
          end
        end
      end
      STG_SIL: begin
        if (play_tick != TickMax) play_tick = play_tick + 1'b1;
        // A gap shortened while silent ends as soon as the count reaches or passes it.
        if (play_tick >= gap_ticks) load_pending();
      end
      default: ;
    endcase
  endfunction

  // Works out the result of one accepted item and advances the player state.
  function automatic out_t play_item(input in_t item);
    out_t res;
    res.byte_taken = 1'b0;
    if (item.mode == CMD_TICK) begin
      // A tick reports the level and busy flag during the tick, before it advances.
      res.tone_out = play_pin;
      res.busy_res = (play_stage != STG_IDLE);
      step_tick();
    end else begin
      // An offer is taken only while idle; a busy block drops it untouched.
      if (play_stage == STG_IDLE) begin
        res.byte_taken = 1'b1;
        queued_code = item.note_byte[3:0];
        queued_valid = 1'b1;
        if (!begin_code(item.note_byte[7:4])) load_pending();
        bytes_taken++;
      end else begin
        bytes_dropped++;
      end
      res.tone_out = play_pin;
      res.busy_res = (play_stage != STG_IDLE);
    end
    return res;
  endfunction

  // Offers one item, waits for the handshake, and records what it must produce. Outside
  // steady mode the sender then either carries on with its burst or idles for a random pause.
  task automatic send_item(input cmd_kind_t kind, input logic [7:0] note);
    in_t item;
    item.mode = kind;
    item.note_byte = note;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(play_item(item));
    items_sent++;
    if (!sender_steady) begin
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  // Holds the sender off until every awaited result has come back, then lets the
  // pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes silence_ticks. The block is drained first so no item is in flight.
  task automatic set_gap(input logic [SilWidth-1:0] ticks);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gap_ticks = ticks;
  endtask

  function automatic logic [7:0] rest_byte();
    return {4'(FirstRest + $urandom_range(0, 1)), 4'(FirstRest + $urandom_range(0, 1))};
  endfunction

  // Ticks while idle must read low and not busy, whatever the ignored byte holds.
  task automatic test_idle_ticks();
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'hFF);
  endtask

  // Starts a rest byte under the reset gap, raises the gap to its maximum while silent,
  // then drops it below the count reached, so the next tick ends the upper code's gap.
  task automatic test_silence_rewrite();
    send_item(CMD_OFFER, {FirstRest, LAST_REST});
    repeat (3) send_item(CMD_TICK, 8'hFF);
    set_gap(TickMax);
    repeat (2) send_item(CMD_TICK, 8'h00);
    set_gap(17'd2);
    repeat (5) send_item(CMD_TICK, 8'($urandom));
  endtask

  // With a zero gap a byte of two rest codes is taken and leaves the block idle at once.
  task automatic test_zero_gap();
    set_gap('0);
    send_item(CMD_OFFER, {LAST_REST, FirstRest});
    send_item(CMD_OFFER, {FirstRest, FirstRest});
    send_item(CMD_TICK, 8'h5A);
  endtask

  // A one-tick gap, and offers that arrive while the block is still busy.
  task automatic test_busy_drop();
    set_gap(17'd1);
    send_item(CMD_OFFER, 8'hFF);
    send_item(CMD_OFFER, 8'h00);
    send_item(CMD_OFFER, {NOTE_A, 1'b1, FirstRest});
    repeat (3) send_item(CMD_TICK, 8'hA5);
  endtask

  // Random rest bytes with random content under several gap settings. Offers while
  // busy carry fully random bytes and are dropped. Idle ticks and dropped offers are
  // noise and do not count toward the item total of a phase.
  task automatic test_random_rests();
    int counted;
    int phase;
    counted = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_gap(17'd1);
        1: set_gap(17'($urandom_range(2, 40)));
        2: set_gap('0);
        default: set_gap(17'($urandom_range(41, 300)));
      endcase
      while (counted < (phase + 1) * 20) begin
        if (play_stage == STG_IDLE) begin
          if ($urandom_range(0, 3) != 0) begin
            send_item(CMD_OFFER, rest_byte());
            counted++;
          end else begin
            send_item(CMD_TICK, 8'($urandom));
          end
        end else if ($urandom_range(0, 9) == 0) begin
          send_item(CMD_OFFER, 8'($urandom));
        end else begin
          send_item(CMD_TICK, 8'($urandom));
          counted++;
        end
        if ($urandom_range(0, 99) == 0) drain();
      end
    end
  endtask

  // Plays note B with a second repetition under a zero gap through its first high half
  // and into the low half. The first stretch runs with stalls on both sides, the rest
  // at full rate, and an offer in the middle is dropped because the block is busy.
  task automatic test_note_run();
    int ticks_done;
    ticks_done = 0;
    set_gap('0);
    send_item(CMD_OFFER, {NOTE_B, 1'b1, FirstRest});
    while (ticks_done < 282) begin
      if (ticks_done == 100) begin
        sender_steady = 1'b1;
        rx_force_open = 1'b1;
      end
      if (ticks_done == 150) send_item(CMD_OFFER, 8'($urandom));
      send_item(CMD_TICK, 8'($urandom));
      ticks_done++;
    end
    sender_steady = 1'b0;
    rx_force_open = 1'b0;
  endtask

  // Starts note G with a second repetition and follows its first ticks; the run ends
  // with the note still playing.
  task automatic test_tail_note();
    set_gap(17'($urandom_range(5, 50)));
    send_item(CMD_OFFER, {NOTE_G, 1'b1, 4'($urandom)});
    repeat (10) begin
      if ($urandom_range(0, 3) == 0) send_item(CMD_OFFER, 8'($urandom));
      else send_item(CMD_TICK, 8'($urandom));
    end
  endtask

  // The receiver changes its stall style every so often. During the second stretch of the
  // note run it is held open so that stretch keeps one item per cycle.
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_window == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_window <= $urandom_range(20, 200);
    end else begin
      rx_window <= rx_window - 1;
    end
    if (rx_force_open) begin
      out_ready <= 1'b1;
    end else begin
      case (rx_style)
        RX_OPEN:   out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_count % 3 != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endtask

  // Every result taken by the receiver is matched against the oldest awaited one.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result item arrived with none awaited: %b", out_data);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("tone_out", want.tone_out, out_data.tone_out);
        check_field("busy_res", want.busy_res, out_data.busy_res);
        check_field("byte_taken", want.byte_taken, out_data.byte_taken);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles,
               due_results.size());
      $display("tb_nibble_tone_sequencer: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_silence_rewrite();
    test_zero_gap();
    test_busy_drop();
    test_random_rests();
    test_note_run();
    test_tail_note();
    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d items and checked %0d results over %0d cycles.", items_sent,
             results_seen, cycles);
    $display("Bytes taken: %0d, dropped while busy: %0d, rests and a note's first half period.",
             bytes_taken, bytes_dropped);
    if (mismatches == 0) begin
      $display("tb_nibble_tone_sequencer: PASS");
    end else begin
      $display("tb_nibble_tone_sequencer: FAIL");
    end
    $finish;
  end

endmodule
